>>> hdl/ngh_pkg.sv
package ngh_pkg;

    localparam int SAMPLE_BITS = 24;

    localparam int LEVEL_W    = 24;
    localparam int GAIN_W     = 24;
    localparam int COEF_W     = 24;
    localparam int K_W        = COEF_W + 1;
    localparam int HOLD_W     = 20;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DOWN_SH = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
    localparam int UP_SH   = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
    localparam int LVL_T_W = SAMPLE_BITS + UP_SH;

    localparam int MUL_A_W = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
    localparam int MUL_B_W = K_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SCL_W   = PROD_W - 23;
    localparam int SNAP_W  = GAIN_W + 6;

    localparam logic [GAIN_W-1:0] Q_ONE     = GAIN_W'(8388608);
    localparam logic [GAIN_W-1:0] SNAP_OPEN = GAIN_W'(8304722);
    localparam logic [K_W-1:0]    ENV_UP_C  = K_W'(2516582);
    localparam logic [K_W-1:0]    ENV_DN_C  = K_W'(16777);
    localparam logic [K_W-1:0]    K_ONE     = K_W'(16777216);
    localparam logic [PROD_W-1:0] ROUND_24  = PROD_W'(1) << 23;
    localparam logic [PROD_W-1:0] ROUND_23  = PROD_W'(1) << 22;
    localparam logic [SNAP_W-1:0] SNAP_MUL_G = SNAP_W'(50);
    localparam logic [SNAP_W-1:0] SNAP_MUL_F = SNAP_W'(51);

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THRESHOLD  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THRESHOLD = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_GAIN      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF   = CFG_IDX_W'(6);

    localparam logic                  RST_GATE_ENABLE     = 1'b1;
    localparam logic [LEVEL_W-1:0]    RST_OPEN_THRESHOLD  = LEVEL_W'(83886);
    localparam logic [LEVEL_W-1:0]    RST_CLOSE_THRESHOLD = LEVEL_W'(59386);
    localparam logic [GAIN_W-1:0]     RST_FLOOR_GAIN      = GAIN_W'(839);
    localparam logic [HOLD_W-1:0]     RST_HOLD_SAMPLES    = HOLD_W'(2400);
    localparam logic [COEF_W-1:0]     RST_ATTACK_COEFF    = COEF_W'(16431500);
    localparam logic [COEF_W-1:0]     RST_RELEASE_COEFF   = COEF_W'(16773721);

    typedef enum logic [PHASE_W-1:0] {
        MODE_CLOSED  = 3'd0,
        MODE_OPENING = 3'd1,
        MODE_OPEN    = 3'd2,
        MODE_HOLDING = 3'd3,
        MODE_CLOSING = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ENV_MUL,
        ST_UPDATE,
        ST_RAMP,
        ST_SCALE_L,
        ST_SCALE_R,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic env_mul;
        logic update;
        logic ramp;
        logic scale_l;
        logic scale_r;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic enabled;
    } stat_t;

    function automatic logic [SAMPLE_BITS-1:0] abs_mag(logic signed [SAMPLE_BITS-1:0] s);
        return s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s) : SAMPLE_BITS'(s);
    endfunction

    function automatic logic [LEVEL_W-1:0] to_level(logic [SAMPLE_BITS-1:0] m);
        logic [LVL_T_W-1:0] t;
        t = LVL_T_W'(m) << UP_SH;
        return LEVEL_W'(t >> DOWN_SH);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(logic [PROD_W-1:0] prod,
                                                                logic neg);
        logic [PROD_W-1:0] sum;
        logic [SCL_W-1:0]  p;
        logic [SCL_W-1:0]  pos_max;
        logic [SCL_W-1:0]  neg_max;
        sum     = prod + ROUND_23;
        p       = SCL_W'(sum >> 23);
        neg_max = SCL_W'(1) << (SAMPLE_BITS - 1);
        pos_max = neg_max - SCL_W'(1);
        if (neg)
        begin
            return (p > neg_max) ? S_MIN : SAMPLE_BITS'(-p);
        end
        return (p > pos_max) ? S_MAX : SAMPLE_BITS'(p);
    endfunction

endpackage

>>> hdl/ngh_frame_if.sv
interface ngh_frame_if
    import ngh_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, left_in, right_in, input ready);
    modport sink (input valid, left_in, right_in, output ready);
endinterface

>>> hdl/ngh_result_if.sv
interface ngh_result_if
    import ngh_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [PHASE_W-1:0]            gate_phase;
    logic [GAIN_W-1:0]             applied_gain;

    modport source (output valid, left_out, right_out, gate_phase, applied_gain, input ready);
    modport sink (input valid, left_out, right_out, gate_phase, applied_gain, output ready);
endinterface

>>> hdl/noise_gate_hysteresis_hold_top.sv
// With the gate on, a frame passes the prep, envelope, update, ramp, left and right scale states
// before the output state; with the gate off it goes from capture straight to the output state.
// A frame is taken only after the last is finished; one multiplier is used four times per frame.
// A finished result waits in the output register while the next frame is taken.
// Reset is asynchronous, active low: the configuration registers take their default values,
// the envelope clears, the gate is closed at the floor gain, and no clearing pass is needed.
module noise_gate_hysteresis_hold_top
    import ngh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ngh_frame_if.sink             frame,
    ngh_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t status;

    ngh_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame.valid),
        .frame_ready  (frame.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    ngh_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .left_in      (frame.left_in),
        .right_in     (frame.right_in),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_out     (result.left_out),
        .right_out    (result.right_out),
        .gate_phase   (result.gate_phase),
        .applied_gain (result.applied_gain)
    );

endmodule

>>> hdl/ngh_ctrl.sv
module ngh_ctrl
    import ngh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  frame_valid,
    output logic  frame_ready,
    output logic  result_valid,
    input  logic  result_ready,
    input  stat_t status,
    output cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        frame_ready    = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                frame_ready = 1'b1;
                if (frame_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.enabled ? ST_PREP : ST_OUT;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_ENV_MUL;
            end
            ST_ENV_MUL:
            begin
                cmd.env_mul = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                cmd.ramp   = 1'b1;
                state_next = ST_SCALE_L;
            end
            ST_SCALE_L:
            begin
                cmd.scale_l = 1'b1;
                state_next  = ST_SCALE_R;
            end
            ST_SCALE_R:
            begin
                cmd.scale_r = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

>>> hdl/ngh_dpath.sv
module ngh_dpath
    import ngh_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output stat_t                         status,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    output logic [PHASE_W-1:0]            gate_phase,
    output logic [GAIN_W-1:0]             applied_gain
);

    logic                en_reg;
    logic [LEVEL_W-1:0]  open_thr_reg;
    logic [LEVEL_W-1:0]  close_thr_reg;
    logic [GAIN_W-1:0]   floor_reg;
    logic [HOLD_W-1:0]   hold_len_reg;
    logic [COEF_W-1:0]   attack_reg;
    logic [COEF_W-1:0]   release_reg;

    logic [LEVEL_W-1:0]  env_reg;
    logic [LEVEL_W-1:0]  env_next;
    logic [GAIN_W-1:0]   gain_reg;
    logic [GAIN_W-1:0]   gain_next;
    mode_t               mode_reg;
    mode_t               mode_next;
    logic [HOLD_W-1:0]   hold_reg;
    logic [HOLD_W-1:0]   hold_next;
    logic                ramp_open_reg;
    logic                ramp_close_reg;

    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic [SAMPLE_BITS-1:0]        lmag_reg;
    logic [SAMPLE_BITS-1:0]        rmag_reg;
    logic [LEVEL_W-1:0]            level_reg;
    logic [LEVEL_W-1:0]            ediff_reg;
    logic                          env_up_reg;
    logic [GAIN_W-1:0]             gdiff_reg;
    logic                          gup_reg;
    logic [K_W-1:0]                kco_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic signed [SAMPLE_BITS-1:0] sl_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [SAMPLE_BITS-1:0] ro_reg;
    mode_t                         phase_reg;
    logic [GAIN_W-1:0]             ag_reg;

    logic [SAMPLE_BITS-1:0] lmag;
    logic [SAMPLE_BITS-1:0] rmag;
    logic [LEVEL_W-1:0]     level;
    logic [GAIN_W-1:0]      gain_target;
    logic [COEF_W-1:0]      ramp_coef;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      env_sum;
    logic [LEVEL_W-1:0]     env_step;
    logic [LEVEL_W-1:0]     env_new;
    mode_t                  mode_upd;
    logic [HOLD_W-1:0]      hold_upd;
    logic                   ramp_open_upd;
    logic                   ramp_close_upd;
    logic [PROD_W-1:0]      ramp_sum;
    logic [K_W-1:0]         ramp_step;
    logic [GAIN_W-1:0]      ramped;
    mode_t                  mode_ramp;
    logic [GAIN_W-1:0]      gain_ramp;

    assign status.enabled = en_reg;

    // Capture: magnitudes and the Q1.23 level of the louder channel.
    always_comb
    begin
        lmag  = abs_mag(left_in);
        rmag  = abs_mag(right_in);
        level = to_level((lmag > rmag) ? lmag : rmag);
    end

    always_comb
    begin
        if (mode_reg == MODE_OPENING)
        begin
            gain_target = Q_ONE;
            ramp_coef   = attack_reg;
        end
        else
        begin
            gain_target = floor_reg;
            ramp_coef   = release_reg;
        end
    end

    // The one shared multiplier serves the envelope, the gain ramp and both samples.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.env_mul)
        begin
            mul_a = MUL_A_W'(ediff_reg);
            mul_b = env_up_reg ? ENV_UP_C : ENV_DN_C;
        end
        else if (cmd.update)
        begin
            mul_a = MUL_A_W'(gdiff_reg);
            mul_b = kco_reg;
        end
        else if (cmd.scale_l)
        begin
            mul_a = MUL_A_W'(lmag_reg);
            mul_b = MUL_B_W'(gain_reg);
        end
        else if (cmd.scale_r)
        begin
            mul_a = MUL_A_W'(rmag_reg);
            mul_b = MUL_B_W'(gain_reg);
        end
        product = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        env_sum        = prod_reg + ROUND_24;
        env_step       = LEVEL_W'(env_sum >> 24);
        env_new        = env_up_reg ? env_reg + env_step : env_reg - env_step;
        mode_upd       = mode_reg;
        hold_upd       = hold_reg;
        ramp_open_upd  = 1'b0;
        ramp_close_upd = 1'b0;
        unique case (mode_reg)
            MODE_OPENING:
            begin
                ramp_open_upd = 1'b1;
            end
            MODE_OPEN:
            begin
                if (env_new < close_thr_reg)
                begin
                    mode_upd = MODE_HOLDING;
                    hold_upd = hold_len_reg;
                end
            end
            MODE_HOLDING:
            begin
                if (env_new >= open_thr_reg)
                begin
                    mode_upd = MODE_OPEN;
                end
                else if (hold_reg != '0)
                begin
                    hold_upd = hold_reg - HOLD_W'(1);
                end
                else
                begin
                    mode_upd = MODE_CLOSING;
                end
            end
            MODE_CLOSING:
            begin
                if (env_new >= open_thr_reg)
                begin
                    mode_upd = MODE_OPENING;
                end
                else
                begin
                    ramp_close_upd = 1'b1;
                end
            end
            default:
            begin
                mode_upd = (env_new >= open_thr_reg) ? MODE_OPENING : MODE_CLOSED;
            end
        endcase
    end

    // A step that rounds to zero still moves the gain one LSB toward its target.
    always_comb
    begin
        ramp_sum  = prod_reg + ROUND_24;
        ramp_step = K_W'(ramp_sum >> 24);
        if (ramp_step == '0 && (!gup_reg || gdiff_reg != '0))
        begin
            ramp_step = K_W'(1);
        end
        ramped    = gup_reg ? GAIN_W'({1'b0, gain_reg} + ramp_step)
                            : GAIN_W'({1'b0, gain_reg} - ramp_step);
        gain_ramp = gain_reg;
        mode_ramp = mode_reg;
        if (ramp_open_reg)
        begin
            if (ramped >= SNAP_OPEN)
            begin
                gain_ramp = Q_ONE;
                mode_ramp = MODE_OPEN;
            end
            else
            begin
                gain_ramp = ramped;
            end
        end
        else if (ramp_close_reg)
        begin
            if (SNAP_W'(ramped) * SNAP_MUL_G <= SNAP_W'(floor_reg) * SNAP_MUL_F)
            begin
                gain_ramp = floor_reg;
                mode_ramp = MODE_CLOSED;
            end
            else
            begin
                gain_ramp = ramped;
            end
        end
    end

    always_comb
    begin
        env_next  = cmd.update ? env_new : env_reg;
        hold_next = cmd.update ? hold_upd : hold_reg;
        gain_next = cmd.ramp ? gain_ramp : gain_reg;
        if (cmd.update)
        begin
            mode_next = mode_upd;
        end
        else if (cmd.ramp)
        begin
            mode_next = mode_ramp;
        end
        else
        begin
            mode_next = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg         <= RST_GATE_ENABLE;
            open_thr_reg   <= RST_OPEN_THRESHOLD;
            close_thr_reg  <= RST_CLOSE_THRESHOLD;
            floor_reg      <= RST_FLOOR_GAIN;
            hold_len_reg   <= RST_HOLD_SAMPLES;
            attack_reg     <= RST_ATTACK_COEFF;
            release_reg    <= RST_RELEASE_COEFF;
            env_reg        <= '0;
            gain_reg       <= RST_FLOOR_GAIN;
            mode_reg       <= MODE_CLOSED;
            hold_reg       <= '0;
            ramp_open_reg  <= 1'b0;
            ramp_close_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GATE_ENABLE:     en_reg        <= cfg_data[0];
                    CFG_OPEN_THRESHOLD:  open_thr_reg  <= LEVEL_W'(cfg_data);
                    CFG_CLOSE_THRESHOLD: close_thr_reg <= LEVEL_W'(cfg_data);
                    CFG_FLOOR_GAIN:      floor_reg     <= GAIN_W'(cfg_data);
                    CFG_HOLD_SAMPLES:    hold_len_reg  <= HOLD_W'(cfg_data);
                    CFG_ATTACK_COEFF:    attack_reg    <= COEF_W'(cfg_data);
                    CFG_RELEASE_COEFF:   release_reg   <= COEF_W'(cfg_data);
                    default:
                    begin
                    end
                endcase
            end
            env_reg  <= env_next;
            gain_reg <= gain_next;
            mode_reg <= mode_next;
            hold_reg <= hold_next;
            if (cmd.update)
            begin
                ramp_open_reg  <= ramp_open_upd;
                ramp_close_reg <= ramp_close_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
            lmag_reg  <= lmag;
            rmag_reg  <= rmag;
            level_reg <= level;
        end
        if (cmd.prep)
        begin
            env_up_reg <= level_reg > env_reg;
            ediff_reg  <= (level_reg > env_reg) ? level_reg - env_reg : env_reg - level_reg;
            gup_reg    <= gain_target >= gain_reg;
            gdiff_reg  <= (gain_target >= gain_reg) ? gain_target - gain_reg
                                                    : gain_reg - gain_target;
            kco_reg    <= K_ONE - K_W'(ramp_coef);
        end
        if (cmd.env_mul || cmd.update || cmd.scale_l || cmd.scale_r)
        begin
            prod_reg <= product;
        end
        if (cmd.scale_r)
        begin
            sl_reg <= scale_sat(prod_reg, left_reg[SAMPLE_BITS-1]);
        end
        if (cmd.finish)
        begin
            phase_reg <= mode_reg;
            if (en_reg)
            begin
                lo_reg <= sl_reg;
                ro_reg <= scale_sat(prod_reg, right_reg[SAMPLE_BITS-1]);
                ag_reg <= gain_reg;
            end
            else
            begin
                lo_reg <= left_reg;
                ro_reg <= right_reg;
                ag_reg <= Q_ONE;
            end
        end
    end

    assign left_out     = lo_reg;
    assign right_out    = ro_reg;
    assign gate_phase   = phase_reg;
    assign applied_gain = ag_reg;

endmodule

>>> tb/ngh_gate_checker.sv
`timescale 1ns / 1ps

module ngh_gate_checker
    import ngh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ngh_frame_if                  frame,
    ngh_result_if                 result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    localparam longint unsigned ONE_Q23      = 64'd8388608;
    localparam longint unsigned ONE_Q24      = 64'd16777216;
    localparam longint unsigned HALF_Q23     = 64'd4194304;
    localparam longint unsigned HALF_Q24     = 64'd8388608;
    localparam longint unsigned ENV_RISE     = 64'd2516582;
    localparam longint unsigned ENV_FALL     = 64'd16777;
    localparam longint unsigned OPEN_SNAP    = 64'd8304722;
    localparam longint unsigned CLOSE_SNAP_G = 64'd50;
    localparam longint unsigned CLOSE_SNAP_F = 64'd51;
    localparam longint unsigned MASK_24      = 64'hFFFFFF;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic [PHASE_W-1:0]     phase;
        logic [GAIN_W-1:0]      gain;
    } gated_frame_t;

    logic            gate_on;
    longint unsigned open_thr;
    longint unsigned close_thr;
    longint unsigned floor_lvl;
    longint unsigned hold_len;
    longint unsigned attack_k;
    longint unsigned release_k;

    longint unsigned envelope;
    longint unsigned gain;
    longint unsigned hold_left;
    mode_t           gate_mode;

    gated_frame_t    gated_frames[$];
    gated_frame_t    oldest;

    function automatic longint unsigned magnitude(input logic signed [SAMPLE_BITS-1:0] s);
        longint v;
        v = s;
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unsigned ramp_toward(input longint unsigned cur,
                                                    input longint unsigned tgt,
                                                    input longint unsigned coeff);
        longint unsigned k;
        longint unsigned d;
        longint unsigned stp;
        k = ONE_Q24 - coeff;
        if (tgt >= cur)
        begin
            d   = tgt - cur;
            stp = (d * k + HALF_Q24) >> 24;
            if (stp == 0 && d != 0)
            begin
                stp = 1;
            end
            return cur + stp;
        end
        d   = cur - tgt;
        stp = (d * k + HALF_Q24) >> 24;
        if (stp == 0)
        begin
            stp = 1;
        end
        return cur - stp;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] scale_sample(
        input logic signed [SAMPLE_BITS-1:0] s,
        input longint unsigned               g);
        longint unsigned p;
        p = (magnitude(s) * g + HALF_Q23) >> 23;
        if (s < 0)
        begin
            return (p > ONE_Q23) ? S_MIN : SAMPLE_BITS'(-p);
        end
        return (p > ONE_Q23 - 1) ? S_MAX : SAMPLE_BITS'(p);
    endfunction

    function automatic gated_frame_t gate_frame(input logic signed [SAMPLE_BITS-1:0] l,
                                                input logic signed [SAMPLE_BITS-1:0] r);
        gated_frame_t    o;
        longint unsigned ml;
        longint unsigned mr;
        longint unsigned lvl;
        ml  = magnitude(l);
        mr  = magnitude(r);
        lvl = (ml > mr) ? ml : mr;
        if (!gate_on)
        begin
            o.left  = l;
            o.right = r;
            o.phase = gate_mode;
            o.gain  = GAIN_W'(ONE_Q23);
            return o;
        end

        if (lvl > envelope)
        begin
            envelope = envelope + (((lvl - envelope) * ENV_RISE + HALF_Q24) >> 24);
        end
        else
        begin
            envelope = envelope - (((envelope - lvl) * ENV_FALL + HALF_Q24) >> 24);
        end
        envelope = envelope & MASK_24;

        case (gate_mode)
            MODE_OPENING:
            begin
                gain = ramp_toward(gain, ONE_Q23, attack_k);
                if (gain >= OPEN_SNAP)
                begin
                    gain      = ONE_Q23;
                    gate_mode = MODE_OPEN;
                end
            end
            MODE_OPEN:
            begin
                if (envelope < close_thr)
                begin
                    gate_mode = MODE_HOLDING;
                    hold_left = hold_len;
                end
            end
            MODE_HOLDING:
            begin
                if (envelope >= open_thr)
                begin
                    gate_mode = MODE_OPEN;
                end
                else if (hold_left > 0)
                begin
                    hold_left = hold_left - 1;
                end
                else
                begin
                    gate_mode = MODE_CLOSING;
                end
            end
            MODE_CLOSING:
            begin
                if (envelope >= open_thr)
                begin
                    gate_mode = MODE_OPENING;
                end
                else
                begin
                    gain = ramp_toward(gain, floor_lvl, release_k);
                    if (gain * CLOSE_SNAP_G <= floor_lvl * CLOSE_SNAP_F)
                    begin
                        gain      = floor_lvl;
                        gate_mode = MODE_CLOSED;
                    end
                end
            end
            default:
            begin
                gate_mode = MODE_CLOSED;
                if (envelope >= open_thr)
                begin
                    gate_mode = MODE_OPENING;
                end
            end
        endcase
        gain = gain & MASK_24;

        o.left  = scale_sample(l, gain);
        o.right = scale_sample(r, gain);
        o.phase = gate_mode;
        o.gain  = GAIN_W'(gain);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            gate_on    = RST_GATE_ENABLE;
            open_thr   = RST_OPEN_THRESHOLD;
            close_thr  = RST_CLOSE_THRESHOLD;
            floor_lvl  = RST_FLOOR_GAIN;
            hold_len   = RST_HOLD_SAMPLES;
            attack_k   = RST_ATTACK_COEFF;
            release_k  = RST_RELEASE_COEFF;
            envelope   = 0;
            gain       = RST_FLOOR_GAIN;
            hold_left  = 0;
            gate_mode  = MODE_CLOSED;
            mismatches = 0;
            gated_frames.delete();
        end
        else
        begin
            // A result never leaves in the cycle its own frame transaction is taken,
            // so the result side is checked before the new frame is predicted.
            if (result.valid && result.ready)
            begin
                if (gated_frames.size() == 0)
                begin
                    $error("result transaction with no frame outstanding");
                    mismatches++;
                end
                else
                begin
                    oldest = gated_frames.pop_front();
                    check_field("left_out", oldest.left, $unsigned(result.left_out));
                    check_field("right_out", oldest.right, $unsigned(result.right_out));
                    check_field("gate_phase", oldest.phase, result.gate_phase);
                    check_field("applied_gain", oldest.gain, result.applied_gain);
                end
            end
            if (frame.valid && frame.ready)
            begin
                gated_frames.push_back(gate_frame(frame.left_in, frame.right_in));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GATE_ENABLE:     gate_on   = cfg_data[0];
                    CFG_OPEN_THRESHOLD:  open_thr  = cfg_data;
                    CFG_CLOSE_THRESHOLD: close_thr = cfg_data;
                    CFG_FLOOR_GAIN:      floor_lvl = cfg_data;
                    CFG_HOLD_SAMPLES:    hold_len  = cfg_data[HOLD_W-1:0];
                    CFG_ATTACK_COEFF:    attack_k  = cfg_data;
                    CFG_RELEASE_COEFF:   release_k = cfg_data;
                    default:             ;
                endcase
            end
        end
        pending = gated_frames.size();
    end

endmodule

>>> tb/tb_noise_gate_hysteresis_hold_top.sv
`timescale 1ns / 1ps

module tb_noise_gate_hysteresis_hold_top;
    import ngh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int          SETTLE_GAP  = 10;
    localparam int          THIRD       = 600;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_IDX_W'(7);
    localparam logic [23:0] LEVEL_MAX = 24'd8388608;
    localparam logic [23:0] COEF_MAX  = 24'hFFFFFF;
    localparam logic [19:0] HOLD_MAX  = 20'hFFFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          mismatches;
    int          pending;
    int          frames_sent;
    int          src_idle_pct;
    int          snk_idle_pct;
    int unsigned cycle_count;

    ngh_frame_if  frame_ch ();
    ngh_result_if result_ch ();

    noise_gate_hysteresis_hold_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ngh_gate_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [23:0] at_level(input int unsigned m);
        int unsigned c;
        c = (m > 8388608) ? 8388608 : m;
        if ($urandom_range(1))
        begin
            return 24'(-c);
        end
        return (c > 8388607) ? 24'd8388607 : 24'(c);
    endfunction

    task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid    <= 1'b1;
        frame_ch.left_in  <= l;
        frame_ch.right_in <= r;
        @(posedge clk);
        while (!frame_ch.ready)
        begin
            @(posedge clk);
        end
        frames_sent++;
        if (frames_sent == THIRD)
        begin
            src_idle_pct = 87;
            snk_idle_pct = 23;
        end
        else if (frames_sent == 2 * THIRD)
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        @(negedge clk);
    endtask

    task automatic settle();
        frame_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_gate(input logic en, input logic [23:0] open_lvl,
                                input logic [23:0] close_lvl, input logic [23:0] floor_lvl,
                                input logic [19:0] hold, input logic [23:0] atk,
                                input logic [23:0] rel);
        settle();
        write_reg(CFG_GATE_ENABLE, 24'(en));
        write_reg(CFG_OPEN_THRESHOLD, open_lvl);
        write_reg(CFG_CLOSE_THRESHOLD, close_lvl);
        write_reg(CFG_FLOOR_GAIN, floor_lvl);
        write_reg(CFG_HOLD_SAMPLES, 24'(hold));
        write_reg(CFG_ATTACK_COEFF, atk);
        write_reg(CFG_RELEASE_COEFF, rel);
    endtask

    // Mostly loud bursts just above the open level followed by quiet stretches,
    // so that the gate walks through all of its states, with some raw noise mixed in.
    task automatic run_bursts(input int n, input int unsigned lvl);
        int sent;
        int seg;
        int i;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) < 7)
            begin
                seg = $urandom_range(40, 5);
                for (i = 0; i < seg && sent < n; i++)
                begin
                    send_frame(at_level(lvl + $urandom_range(lvl / 64)),
                               at_level($urandom_range(lvl)));
                    sent++;
                end
                seg = $urandom_range(60, 5);
                for (i = 0; i < seg && sent < n; i++)
                begin
                    send_frame(at_level($urandom_range(lvl / 8)),
                               at_level($urandom_range(lvl / 8)));
                    sent++;
                end
            end
            else
            begin
                seg = $urandom_range(10, 1);
                for (i = 0; i < seg && sent < n; i++)
                begin
                    send_frame(24'($urandom), 24'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [23:0] open_lvl;
        logic [23:0] atk;
        logic [23:0] rel;
        int          k;
        rst_n             = 1'b0;
        frame_ch.valid    = 1'b0;
        frame_ch.left_in  = '0;
        frame_ch.right_in = '0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        frames_sent       = 0;
        src_idle_pct      = 23;
        snk_idle_pct      = 87;
        cycle_count       = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_frame(S_MAX, S_MAX);
        send_frame(S_MIN, S_MIN);
        send_frame(S_MIN, S_MAX);
        send_frame(S_MAX, S_MIN);
        send_frame(24'd0, 24'd0);
        send_frame(24'd1, 24'hFFFFFF);
        send_frame(24'hFFFFFF, 24'd1);
        send_frame(24'h555555, 24'hAAAAAA);
        send_frame(24'hAAAAAA, 24'h555555);

        settle();
        write_reg(CFG_GATE_ENABLE, 24'd0);
        write_reg(CFG_NO_REG, 24'h123456);
        send_frame(S_MIN, S_MAX);
        send_frame(S_MAX, S_MIN);
        send_frame(24'd0, 24'd0);
        send_frame(24'h2AAAAA, 24'hD55555);

        settle();
        write_reg(CFG_GATE_ENABLE, 24'd1);
        run_bursts(200, 90000);

        program_gate(1'b1, 24'd1000000, 24'd992000, 24'($urandom_range(8388608)),
                     20'($urandom_range(8)), 24'($urandom_range(8388607)),
                     24'($urandom_range(8388607)));
        run_bursts(220, 1000000);

        settle();
        write_reg(CFG_GATE_ENABLE, 24'd0);
        run_bursts(60, 1000000);
        settle();
        write_reg(CFG_GATE_ENABLE, 24'd1);
        run_bursts(80, 1000000);

        program_gate(1'b1, 24'd0, 24'd0, 24'd0, 20'd0, 24'd0, 24'd0);
        run_bursts(100, 4096);

        program_gate(1'b1, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, HOLD_MAX, COEF_MAX, COEF_MAX);
        run_bursts(60, 8388608);

        program_gate(1'b1, 24'd100000, LEVEL_MAX, LEVEL_MAX, HOLD_MAX, 24'd0, COEF_MAX);
        run_bursts(100, 100000);

        program_gate(1'b1, 24'd200000, 24'd198000, 24'd12582912, 20'd0, 24'd0, COEF_MAX);
        run_bursts(120, 200000);

        program_gate(1'b1, 24'd300000, 24'd297000, 24'd4000, 20'd0, COEF_MAX, 24'd0);
        run_bursts(80, 300000);

        for (k = 0; k < 5; k++)
        begin
            open_lvl = 24'($urandom_range(8388608, 2000));
            atk = $urandom_range(1) ? 24'($urandom_range(15000000)) : 24'($urandom);
            rel = $urandom_range(1) ? 24'($urandom_range(15000000)) : 24'($urandom);
            program_gate(1'b1, open_lvl, open_lvl - 24'($urandom_range(open_lvl / 32)),
                         24'($urandom_range(8388608)), 20'($urandom_range(30)), atk, rel);
            run_bursts(150, open_lvl);
        end

        settle();
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
